@@ hw/rtl/i2crts_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register transfer sequencer package
// Word layouts and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2crts_pkg;

  localparam int unsigned LEN_W = 9;
  localparam int unsigned ATT_W = 4;

  localparam logic [LEN_W-1:0] MAX_LENGTH   = 9'd256;
  localparam logic [ATT_W-1:0] ATT_LIMIT    = 4'd15;
  localparam logic [ATT_W-1:0] ATT_RESET    = 4'd8;
  localparam logic [7:0]       FAIL_RX_BYTE = 8'hFF;

  localparam logic MODE_REQUEST    = 1'b0;
  localparam logic MODE_COMPLETION = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [6:0]       dev_addr;
    logic [7:0]       reg_addr;
    logic             is_read;
    logic [LEN_W-1:0] length;
    logic             ack_seen;
    logic [7:0]       rx_data;
    logic [7:0]       tx_data;
  } in_word_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [7:0] cmd_byte;
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_receive;
    logic       cmd_master_ack;
    logic       cmd_error;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       success;
  } out_word_t;

endpackage : i2crts_pkg

`default_nettype wire

@@ hw/rtl/i2crts_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted word until the sequencer consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crts_in_reg
  import i2crts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic     advance,
  output logic          q_valid,
  output in_word_t      q_word
);

  logic     q_valid_r;
  in_word_t q_word_r;

  assign in_ready = !q_valid_r || advance;
  assign q_valid  = q_valid_r;
  assign q_word   = q_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ready) begin
      q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_word_r <= in_word;
    end
  end

endmodule : i2crts_in_reg

`default_nettype wire

@@ hw/rtl/i2crts_seq.sv @@
// ----------------------------------------------------------------------------
// Transfer sequencer core
// Phase state, retry count, byte count and the next-command decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crts_seq
  import i2crts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [ATT_W-1:0] cfg_data,
  input  wire logic             fire,
  input  wire in_word_t         q_word,
  output out_word_t             res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ADDR_W,
    PH_REG,
    PH_ADDR_R,
    PH_DATA_R,
    PH_LAST_R,
    PH_DATA_W,
    PH_LAST_W,
    PH_RETRY
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [ATT_W-1:0] max_att_r;
  logic [ATT_W-1:0] att_r, att_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [6:0]       dev_r, dev_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic             dir_r, dir_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    logic [ATT_W-1:0] att_inc;
    logic [LEN_W-1:0] left_dec;
    logic [LEN_W-1:0] len;
    res       = '0;
    phase_nxt = phase_r;
    att_nxt   = att_r;
    left_nxt  = left_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    dir_nxt   = dir_r;
    att_inc   = (att_r < ATT_LIMIT) ? att_r + 1'b1 : att_r;
    left_dec  = (left_r > 9'd1) ? left_r - 1'b1 : left_r;
    len       = q_word.length;
    if (len == '0) begin
      len = 9'd1;
    end else if (len > MAX_LENGTH) begin
      len = MAX_LENGTH;
    end

    if (q_word.mode == MODE_REQUEST) begin
      if (phase_r == PH_IDLE) begin
        dev_nxt       = q_word.dev_addr;
        reg_nxt       = q_word.reg_addr;
        dir_nxt       = q_word.is_read;
        left_nxt      = len;
        att_nxt       = '0;
        res.cmd_valid = 1'b1;
        res.cmd_byte  = {q_word.dev_addr, 1'b0};
        res.cmd_start = 1'b1;
        phase_nxt     = PH_ADDR_W;
      end
    end else begin
      case (phase_r)
        PH_RETRY: begin
          res.cmd_valid = 1'b1;
          res.cmd_byte  = {dev_r, 1'b0};
          res.cmd_start = 1'b1;
          phase_nxt     = PH_ADDR_W;
        end
        PH_ADDR_W, PH_REG, PH_ADDR_R: begin
          if (!q_word.ack_seen) begin
            // address-phase NACK: error stop, then retry or fail
            res.cmd_valid = 1'b1;
            res.cmd_stop  = 1'b1;
            res.cmd_error = 1'b1;
            att_nxt       = att_inc;
            if (att_inc >= max_att_r) begin
              res.done_res = 1'b1;
              res.rx_byte  = FAIL_RX_BYTE;
              phase_nxt    = PH_IDLE;
            end else begin
              phase_nxt = PH_RETRY;
            end
          end else if (phase_r == PH_ADDR_W) begin
            res.cmd_valid = 1'b1;
            res.cmd_byte  = reg_r;
            phase_nxt     = PH_REG;
          end else if (phase_r == PH_REG && dir_r) begin
            res.cmd_valid = 1'b1;
            res.cmd_byte  = {dev_r, 1'b1};
            res.cmd_start = 1'b1;
            phase_nxt     = PH_ADDR_R;
          end else if (phase_r == PH_REG) begin
            res.cmd_valid = 1'b1;
            res.cmd_byte  = q_word.tx_data;
            res.cmd_stop  = (left_r <= 9'd1);
            phase_nxt     = (left_r <= 9'd1) ? PH_LAST_W : PH_DATA_W;
          end else begin
            res.cmd_valid      = 1'b1;
            res.cmd_receive    = 1'b1;
            res.cmd_stop       = (left_r <= 9'd1);
            res.cmd_master_ack = (left_r > 9'd1);
            phase_nxt          = (left_r <= 9'd1) ? PH_LAST_R : PH_DATA_R;
          end
        end
        PH_DATA_R: begin
          res.rx_valid       = 1'b1;
          res.rx_byte        = q_word.rx_data;
          left_nxt           = left_dec;
          res.cmd_valid      = 1'b1;
          res.cmd_receive    = 1'b1;
          res.cmd_stop       = (left_dec <= 9'd1);
          res.cmd_master_ack = (left_dec > 9'd1);
          phase_nxt          = (left_dec <= 9'd1) ? PH_LAST_R : PH_DATA_R;
        end
        PH_LAST_R: begin
          res.rx_valid = 1'b1;
          res.rx_byte  = q_word.rx_data;
          res.done_res = 1'b1;
          res.success  = 1'b1;
          phase_nxt    = PH_IDLE;
        end
        PH_DATA_W: begin
          if (q_word.ack_seen) begin
            left_nxt      = left_dec;
            res.cmd_valid = 1'b1;
            res.cmd_byte  = q_word.tx_data;
            res.cmd_stop  = (left_dec <= 9'd1);
            phase_nxt     = (left_dec <= 9'd1) ? PH_LAST_W : PH_DATA_W;
          end else begin
            res.cmd_valid = 1'b1;
            res.cmd_stop  = 1'b1;
            res.cmd_error = 1'b1;
            res.done_res  = 1'b1;
            res.rx_byte   = FAIL_RX_BYTE;
            phase_nxt     = PH_IDLE;
          end
        end
        PH_LAST_W: begin
          res.done_res = 1'b1;
          if (q_word.ack_seen) begin
            res.success = 1'b1;
          end else begin
            res.cmd_valid = 1'b1;
            res.cmd_stop  = 1'b1;
            res.cmd_error = 1'b1;
            res.rx_byte   = FAIL_RX_BYTE;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      att_r     <= '0;
      left_r    <= '0;
      dev_r     <= '0;
      reg_r     <= '0;
      dir_r     <= 1'b0;
      max_att_r <= ATT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_att_r <= cfg_data;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        att_r   <= att_nxt;
        left_r  <= left_nxt;
        dev_r   <= dev_nxt;
        reg_r   <= reg_nxt;
        dir_r   <= dir_nxt;
      end
    end
  end

endmodule : i2crts_seq

`default_nettype wire

@@ hw/rtl/i2crts_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crts_out_reg
  import i2crts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_word_t res,
  output logic           advance,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic      out_valid_r;
  out_word_t out_word_r;

  assign advance   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && advance) begin
      out_word_r <= res;
    end
  end

endmodule : i2crts_out_reg

`default_nettype wire

@@ hw/rtl/i2c_register_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C register transfer sequencer
// Issues byte commands to an I2C byte engine for register reads and writes.
//
//   channel   dir  handshake              payload
//   in_       in   in_valid / in_ready    in_word  (in_word_t)
//   out_      out  out_valid / out_ready  out_word (out_word_t)
//   cfg_      in   cfg_valid / cfg_ready  cfg_data (max_attempts)
//
// One word per cycle while out_ready is high; each word passes the input register,
// then the result register. Reset clears phase, counters and both valid flags.
// out_ready low holds the result; in_ready drops while both registers are
// full and out_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transfer_sequencer
  import i2crts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_word,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [ATT_W-1:0] cfg_data
);

  logic      advance;
  logic      q_valid;
  in_word_t  q_word;
  out_word_t res;

  i2crts_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_word   (q_word)
  );

  i2crts_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (q_valid && advance),
    .q_word    (q_word),
    .res       (res)
  );

  i2crts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (q_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule : i2c_register_transfer_sequencer

`default_nettype wire

@@ hw/rtl/i2crts_checker.sv @@
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level ports for result stability and encoding rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2crts_checker
  import i2crts_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.done_res && !out_word.success |->
      out_word.rx_byte == FAIL_RX_BYTE && out_word.cmd_stop && out_word.cmd_error)
    else $error("failed transfer without error stop");

  a_recv_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.cmd_receive |->
      out_word.cmd_byte == 8'h00 && !out_word.cmd_start && !out_word.cmd_error)
    else $error("malformed receive command");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : i2crts_checker

bind i2c_register_transfer_sequencer i2crts_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
